>>> design/mfd_pkg.sv
package mfd_pkg;

	localparam int SAMPLE_W         = 24;
	localparam int CH_W             = 1;
	localparam int CHANNELS         = 2;
	localparam int BUFFER_DEPTH     = 4096;
	localparam int ADDR_W           = $clog2(BUFFER_DEPTH);
	localparam int RAM_DEPTH        = CHANNELS * BUFFER_DEPTH;
	localparam int RAM_AW           = CH_W + ADDR_W;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
	localparam int ROM_AW           = IDX_W + 1;
	localparam int SINE_SHIFT       = SAMPLE_W - 1;

	localparam int DELAY_W          = 20;
	localparam int DEPTH_W          = 20;
	localparam int STEP_W           = 32;
	localparam int FRAC_W           = 8;
	localparam int WGT_W            = FRAC_W + 1;

	localparam int CFG_W            = 32;
	localparam int CFG_IDX_W        = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;

	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
	localparam int CNT_W            = $clog2(FIFO_DEPTH + 1);

	// sine magnitude is signed 25 bits, depth signed 20 bits
	localparam int PROD_W           = DEPTH_W + SAMPLE_W + 1;
	localparam int LFO_W            = PROD_W - SINE_SHIFT;
	localparam int SUM_W            = DELAY_W + 3;
	localparam int TOT_W            = ADDR_W + FRAC_W;
	localparam int MIN_TOTAL        = 1 << FRAC_W;
	localparam int MAX_TOTAL        = (BUFFER_DEPTH - 2) << FRAC_W;

	localparam int ACC_W            = SAMPLE_W + WGT_W;
	localparam int Y_W              = ACC_W + 1 - FRAC_W;
	localparam int HALF_LSB         = 1 << (FRAC_W - 1);
	localparam int SAMPLE_MAX       = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN       = -(1 << (SAMPLE_W - 1));

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	typedef logic [SAMPLE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	typedef struct packed {
		logic [DELAY_W-1:0]        delay;
		logic signed [DEPTH_W-1:0] depth;
		logic [STEP_W-1:0]         step;
	} cfg_t;

	typedef struct packed {
		logic                       bypass;
		logic [CH_W-1:0]            ch;
		logic signed [SAMPLE_W-1:0] sample;
		logic [ADDR_W-1:0]          d1;
		logic [FRAC_W-1:0]          g;
	} dly_job_t;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} q_stat_t;

	// Taylor series of sin over the first quadrant, Q30 internally
	function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned i);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x2) / SINE_DIV[k];
			if (k % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = 0;
		sum = (sum + 64) >>> 7;
		if (sum > (64'sd1 <<< SINE_SHIFT))
			sum = 64'sd1 <<< SINE_SHIFT;
		return sum[SAMPLE_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
			r[i] = sine_entry(i);
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> design/mfd_in_if.sv
interface mfd_in_if;
	import mfd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [CH_W-1:0]            channel;

	modport source(output valid, sample_in, channel, input ready);
	modport sink(input valid, sample_in, channel, output ready);
endinterface

>>> design/mfd_out_if.sv
interface mfd_out_if;
	import mfd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [CH_W-1:0]            out_channel;

	modport source(output valid, sample_out, out_channel, input ready);
	modport sink(input valid, sample_out, out_channel, output ready);
endinterface

>>> design/mfd_ram.sv
module mfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

>>> design/mfd_front.sv
module mfd_front (
	input  logic              clk,
	input  logic              arst_n,
	mfd_in_if.sink            din,
	input  mfd_pkg::cfg_t     cfg,
	input  mfd_pkg::q_stat_t  q_stat,
	output logic              push,
	output mfd_pkg::dly_job_t push_data
);
	import mfd_pkg::*;

	logic [STEP_W-1:0]          phase_q [CHANNELS];
	logic [STEP_W-1:0]          ph;
	logic [IDX_W-1:0]           idx;
	logic [ROM_AW-1:0]          rom_idx;
	logic                       byp;
	logic                       accept;
	logic [CNT_W:0]             occ;

	logic                       v_s1, v_s2, v_s3;
	logic                       byp_s1, byp_s2, byp_s3;
	logic [CH_W-1:0]            ch_s1, ch_s2, ch_s3;
	logic signed [SAMPLE_W-1:0] smp_s1, smp_s2, smp_s3;
	logic                       neg_s1;
	logic [ROM_AW-1:0]          rom_idx_s1;
	logic signed [SAMPLE_W:0]   sine_s2;
	logic signed [PROD_W-1:0]   prod_s3;

	logic [SAMPLE_W-1:0]        rom_mag;
	logic signed [PROD_W-1:0]   rnd;
	logic signed [LFO_W-1:0]    lfo;
	logic signed [SUM_W-1:0]    tot;
	logic [TOT_W-1:0]           tot_c;

	// items in flight in the front count against queue space
	assign occ = {1'b0, q_stat.count} + (CNT_W + 1)'(v_s1) + (CNT_W + 1)'(v_s2)
		+ (CNT_W + 1)'(v_s3);
	assign din.ready = (occ < (CNT_W + 1)'(FIFO_DEPTH));
	assign accept = din.valid && din.ready;

	assign byp = (cfg.delay < DELAY_W'(MIN_TOTAL)) || (32'(din.channel) >= CHANNELS);
	assign ph = phase_q[din.channel];
	assign idx = ph[STEP_W-3 -: IDX_W];
	assign rom_idx = ph[STEP_W-2] ? ROM_AW'(SINE_TABLE_DEPTH) - {1'b0, idx} : {1'b0, idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++)
				phase_q[c] <= '0;
		end else if (accept && !byp) begin
			phase_q[din.channel] <= ph + cfg.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign rom_mag = SINE_ROM[rom_idx_s1];

	always_ff @(posedge clk) begin
		byp_s1     <= byp;
		ch_s1      <= din.channel;
		smp_s1     <= din.sample_in;
		neg_s1     <= ph[STEP_W-1];
		rom_idx_s1 <= rom_idx;

		byp_s2     <= byp_s1;
		ch_s2      <= ch_s1;
		smp_s2     <= smp_s1;
		sine_s2    <= neg_s1 ? -$signed({1'b0, rom_mag}) : $signed({1'b0, rom_mag});

		byp_s3     <= byp_s2;
		ch_s3      <= ch_s2;
		smp_s3     <= smp_s2;
		prod_s3    <= cfg.depth * sine_s2;
	end

	// lfo rounded half up, then clamp the read distance
	always_comb begin
		rnd = prod_s3 + $signed(PROD_W'(1) << (SINE_SHIFT - 1));
		lfo = rnd[PROD_W-1:SINE_SHIFT];
		tot = $signed(SUM_W'(cfg.delay)) + SUM_W'(lfo);
		if (tot < $signed(SUM_W'(MIN_TOTAL)))
			tot_c = TOT_W'(MIN_TOTAL);
		else if (tot > $signed(SUM_W'(MAX_TOTAL)))
			tot_c = TOT_W'(MAX_TOTAL);
		else
			tot_c = tot[TOT_W-1:0];
	end

	assign push             = v_s3;
	assign push_data.bypass = byp_s3;
	assign push_data.ch     = ch_s3;
	assign push_data.sample = smp_s3;
	assign push_data.d1     = tot_c[TOT_W-1:FRAC_W];
	assign push_data.g      = tot_c[FRAC_W-1:0];

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (CNT_W + 1)'(FIFO_DEPTH))
		else $error("front: items in flight exceed queue space");
endmodule

>>> design/mfd_queue.sv
module mfd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mfd_pkg::dly_job_t push_data,
	input  logic              pop,
	output mfd_pkg::dly_job_t head,
	output mfd_pkg::q_stat_t  stat
);
	import mfd_pkg::*;

	dly_job_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(FIFO_DEPTH)) |-> !push)
		else $error("queue: push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue: pop while empty");
endmodule

>>> design/mfd_back.sv
module mfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mfd_pkg::dly_job_t head,
	input  mfd_pkg::q_stat_t  q_stat,
	output logic              pop,
	mfd_out_if.source         dout
);
	import mfd_pkg::*;

	logic [ADDR_W-1:0]          wp_q [CHANNELS];
	logic                       full_q [CHANNELS];

	logic                       busy2_q;
	logic                       fin_q;
	logic [CH_W-1:0]            ch_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic [FRAC_W-1:0]          g_q;
	logic [ADDR_W-1:0]          i2_q;
	logic                       v1_q, v2_q;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       out_v_q;
	logic signed [SAMPLE_W-1:0] out_smp_q;
	logic [CH_W-1:0]            out_ch_q;

	logic [ADDR_W-1:0]          hwp;
	logic [ADDR_W-1:0]          i1, i2;
	logic                       hv1, hv2;
	logic                       out_free, fin_go, pop_byp, pop_dly;

	logic                       ram_we, ram_re;
	logic [RAM_AW-1:0]          ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0]        ram_rdata;

	logic signed [SAMPLE_W-1:0] tap1, tap2;
	logic [WGT_W-1:0]           w1;
	logic signed [ACC_W:0]      sum, rnd;
	logic signed [Y_W-1:0]      yw;
	logic signed [SAMPLE_W-1:0] y;

	// an entry counts as written once the pointer has passed it or wrapped
	assign hwp = wp_q[head.ch];
	assign i1  = hwp - head.d1;
	assign i2  = i1 - 1'b1;
	assign hv1 = full_q[head.ch] || (i1 < hwp);
	assign hv2 = full_q[head.ch] || (i2 < hwp);

	assign out_free = !out_v_q || dout.ready;
	assign fin_go   = fin_q && out_free;
	assign pop_byp  = !q_stat.empty && head.bypass && !busy2_q && !fin_q && out_free;
	assign pop_dly  = !q_stat.empty && !head.bypass && !busy2_q && (!fin_q || fin_go);
	assign pop      = pop_byp || pop_dly;

	// first tap on pop, second tap together with the new sample write
	assign ram_re    = pop_dly || busy2_q;
	assign ram_raddr = pop_dly ? {head.ch, i1} : {ch_q, i2_q};
	assign ram_we    = busy2_q;
	assign ram_waddr = {ch_q, wp_q[ch_q]};

	mfd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (samp_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign tap1 = v1_q ? $signed(ram_rdata) : '0;
	assign tap2 = v2_q ? $signed(ram_rdata) : '0;
	assign w1   = WGT_W'(1 << FRAC_W) - {1'b0, g_q};

	always_comb begin
		sum = acc_q + $signed({1'b0, g_q}) * tap2;
		rnd = sum + $signed((ACC_W + 1)'(HALF_LSB));
		yw  = rnd[ACC_W:FRAC_W];
		if (yw > Y_W'(SAMPLE_MAX))
			y = SAMPLE_W'(SAMPLE_MAX);
		else if (yw < Y_W'(SAMPLE_MIN))
			y = SAMPLE_W'(SAMPLE_MIN);
		else
			y = yw[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (pop_dly) begin
			ch_q   <= head.ch;
			samp_q <= head.sample;
			g_q    <= head.g;
			i2_q   <= i2;
			v1_q   <= hv1;
			v2_q   <= hv2;
		end
		if (busy2_q)
			acc_q <= $signed({1'b0, w1}) * tap1;
		if (fin_go) begin
			out_smp_q <= y;
			out_ch_q  <= ch_q;
		end else if (pop_byp) begin
			out_smp_q <= head.sample;
			out_ch_q  <= head.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy2_q <= 1'b0;
			fin_q   <= 1'b0;
			out_v_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]   <= '0;
				full_q[c] <= 1'b0;
			end
		end else begin
			busy2_q <= pop_dly;
			fin_q   <= busy2_q || (fin_q && !fin_go);
			if (fin_go || pop_byp)
				out_v_q <= 1'b1;
			else if (dout.ready)
				out_v_q <= 1'b0;
			if (busy2_q) begin
				wp_q[ch_q] <= wp_q[ch_q] + 1'b1;
				if (wp_q[ch_q] == ADDR_W'(BUFFER_DEPTH - 1))
					full_q[ch_q] <= 1'b1;
			end
		end
	end

	assign dout.valid       = out_v_q;
	assign dout.sample_out  = out_smp_q;
	assign dout.out_channel = out_ch_q;

	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy2_q && fin_q))
		else $error("back: second read overlaps finish");
	a_read2_then_fin: assert property (@(posedge clk) disable iff (!arst_n)
		busy2_q |=> fin_q)
		else $error("back: second tap not followed by finish");
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && !out_free) |=> (fin_q && $stable(acc_q) && $stable(ram_rdata)))
		else $error("back: stalled result lost");
endmodule

>>> design/modulated_fractional_delay_core.sv
// Per-channel LFO-modulated delay line with linear interpolation between two
// neighboring taps. Samples go in on din with their channel number and come
// out on dout in the same order, one result per sample. A delayed item needs
// two reads in the back end, one at a time through the single read port of
// the sample store (first tap, then second tap together with the write of
// the new sample); a bypass item skips the store. Three front stages compute
// the sine lookup, the depth multiply and the clamped read distance, and a
// four-entry queue decouples them from the memory sequencer. The store needs
// no clearing pass after reset: a per-channel fill mark makes never-written
// taps read as zero. The user must write registers through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
module modulated_fractional_delay_core (
	input  logic                            clk,
	input  logic                            arst_n,
	mfd_in_if.sink                          din,
	mfd_out_if.source                       dout,
	input  logic                            cfg_we,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfd_pkg::CFG_W-1:0]       cfg_wdata
);
	import mfd_pkg::*;

	cfg_t     cfg_q;
	logic     push, pop;
	dly_job_t push_data, head;
	q_stat_t  q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY: cfg_q.delay <= cfg_wdata[DELAY_W-1:0];
				REG_DEPTH: cfg_q.depth <= $signed(cfg_wdata[DEPTH_W-1:0]);
				REG_STEP:  cfg_q.step  <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	mfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	mfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	mfd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.dout   (dout)
	);
endmodule

>>> sim/modulated_fractional_delay_core_tb.sv
`timescale 1ns / 100ps

module modulated_fractional_delay_core_tb;
	import mfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [SAMPLE_W-1:0]  S_MAX     = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0]  S_MIN     = 24'h800000;
	localparam longint MIN_DIST    = 256;
	localparam longint MAX_DIST    = longint'(BUFFER_DEPTH - 2) * 256;
	localparam longint SAT_HI      = 8388607;
	localparam longint SAT_LO      = -8388608;
	localparam longint HALF_PI_FX  = 1686629713;
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     HOLD_CYCLES = 300;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]            ch;
	} tap_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	mfd_in_if  din_bus();
	mfd_out_if dout_bus();

	modulated_fractional_delay_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	int                         sine_tab [0:SINE_TABLE_DEPTH];
	logic signed [SAMPLE_W-1:0] delay_mem [0:CHANNELS-1][0:BUFFER_DEPTH-1];
	logic [ADDR_W-1:0]          wr_ptr [0:CHANNELS-1];
	logic [STEP_W-1:0]          lfo_phase [0:CHANNELS-1];
	logic [DELAY_W-1:0]         base_delay;
	logic signed [DEPTH_W-1:0]  swing;
	logic [STEP_W-1:0]          phase_inc;

	tap_result_t awaited_outputs[$];
	int fail_count = 0;
	int cycle_count = 0;
	int hold_left = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// first-quadrant sine, Q23, odd Taylor terms up to x^15
	function automatic int quarter_sine(input int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		int k;
		x = longint'(HALF_PI_FX) * i / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (k = 1; k <= 7; k++) begin
			term = term * x2 / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		acc = (acc + 64) >>> 7;
		if (acc > (64'sd1 <<< 23))
			acc = 64'sd1 <<< 23;
		return int'(acc);
	endfunction

	function automatic longint sine_at(input logic [STEP_W-1:0] ph);
		int idx;
		longint mag;
		idx = int'((longint'(ph[29:0]) * SINE_TABLE_DEPTH) >> 30);
		if (ph[30])
			mag = sine_tab[SINE_TABLE_DEPTH - idx];
		else
			mag = sine_tab[idx];
		return ph[31] ? -mag : mag;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] interpolate_delayed(
			input logic signed [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch);
		longint swing_now;
		longint total;
		longint mix;
		int d1;
		int g;
		int wp;
		int tap_a;
		int tap_b;
		if (base_delay < MIN_DIST || int'(ch) >= CHANNELS)
			return smp;
		// LFO uses the phase before this sample's increment
		swing_now = (longint'(swing) * sine_at(lfo_phase[ch]) + (64'sd1 <<< 22)) >>> 23;
		lfo_phase[ch] = lfo_phase[ch] + phase_inc;
		total = longint'(base_delay) + swing_now;
		if (total < MIN_DIST)
			total = MIN_DIST;
		if (total > MAX_DIST)
			total = MAX_DIST;
		d1 = int'(total >>> FRAC_W);
		g = int'(total & 255);
		wp = int'(wr_ptr[ch]);
		tap_a = (wp + BUFFER_DEPTH - d1) % BUFFER_DEPTH;
		tap_b = (wp + 2 * BUFFER_DEPTH - d1 - 1) % BUFFER_DEPTH;
		mix = longint'(256 - g) * longint'(delay_mem[ch][tap_a])
			+ longint'(g) * longint'(delay_mem[ch][tap_b]);
		mix = (mix + 128) >>> 8;
		if (mix > SAT_HI)
			mix = SAT_HI;
		if (mix < SAT_LO)
			mix = SAT_LO;
		delay_mem[ch][wp] = smp;
		wr_ptr[ch] = ADDR_W'((wp + 1) % BUFFER_DEPTH);
		return mix[SAMPLE_W-1:0];
	endfunction

	task automatic clear_model();
		int i;
		int c;
		for (i = 0; i <= SINE_TABLE_DEPTH; i++)
			sine_tab[i] = quarter_sine(i);
		for (c = 0; c < CHANNELS; c++) begin
			for (i = 0; i < BUFFER_DEPTH; i++)
				delay_mem[c][i] = '0;
			wr_ptr[c] = '0;
			lfo_phase[c] = '0;
		end
		base_delay = '0;
		swing = '0;
		phase_inc = '0;
	endtask

	// leaves cfg_we high; program_regs lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_DELAY: base_delay = data[DELAY_W-1:0];
			REG_DEPTH: swing = data[DEPTH_W-1:0];
			REG_STEP:  phase_inc = data[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [DELAY_W-1:0] dly,
			input logic signed [DEPTH_W-1:0] dep, input logic [STEP_W-1:0] stp);
		write_reg(REG_DELAY, CFG_W'(dly));
		write_reg(REG_DEPTH, {{(CFG_W - DEPTH_W){dep[DEPTH_W-1]}}, dep});
		write_reg(REG_STEP, CFG_W'(stp));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch);
		tap_result_t r;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			din_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		din_bus.valid <= 1'b1;
		din_bus.sample_in <= smp;
		din_bus.channel <= ch;
		do @(posedge clk); while (!din_bus.ready);
		r.sample = interpolate_delayed(smp, ch);
		r.ch = ch;
		awaited_outputs.push_back(r);
	endtask

	task automatic wait_all_results();
		din_bus.valid <= 1'b0;
		do @(posedge clk); while (awaited_outputs.size() != 0);
	endtask

	task automatic test_bypass();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b1);
		send_sample(24'h000000, 1'b0);
		send_sample(24'hFFFFFF, 1'b1);
		wait_all_results();
		// spare index must not disturb anything; delay one LSB short of a sample
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		program_regs(20'd255, 20'sh7FFFF, 32'h4000_0000);
		send_sample(24'h555555, 1'b0);
		send_sample(24'hAAAAAA, 1'b1);
		wait_all_results();
	endtask

	task automatic test_fixed_delay();
		program_regs(20'd256, 20'sd0, 32'd0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(24'd123, 1'b1);
		send_sample(24'd0, 1'b0);
		wait_all_results();
		// one-and-a-half-sample delay mixes neighbors equally
		program_regs(20'd384, 20'sd0, 32'd0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		wait_all_results();
		// longest distance, clamped to the buffer end
		program_regs(20'hFFFFF, 20'sd0, 32'd0);
		send_sample(24'h0F0F0F, 1'b1);
		wait_all_results();
	endtask

	task automatic test_lfo_sweep();
		// quarter-turn step walks through all four quadrants
		program_regs(20'd2048, 20'sd1024, 32'h4000_0000);
		repeat (4)
			send_sample(SAMPLE_W'($urandom), 1'b0);
		repeat (2)
			send_sample(SAMPLE_W'($urandom), 1'b1);
		wait_all_results();
		// full negative swing against a negative sine lengthens the distance
		program_regs(20'd256, 20'sh80000, 32'h4000_0000);
		repeat (3)
			send_sample(SAMPLE_W'($urandom), 1'b1);
		wait_all_results();
		program_regs(20'd524288, 20'sh7FFFF, 32'hFFFF_FFFF);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b1);
		wait_all_results();
	endtask

	task automatic random_regs();
		logic [DELAY_W-1:0] dly;
		logic signed [DEPTH_W-1:0] dep;
		logic [STEP_W-1:0] stp;
		case ($urandom_range(9))
			0: dly = DELAY_W'($urandom_range(255));
			1: dly = DELAY_W'($urandom);
			default: dly = DELAY_W'($urandom_range(256, 24 * 256));
		endcase
		case ($urandom_range(3))
			0: dep = '0;
			1: dep = DEPTH_W'($urandom);
			default: begin
				dep = DEPTH_W'($urandom_range(8 * 256));
				if ($urandom_range(1))
					dep = -dep;
			end
		endcase
		case ($urandom_range(3))
			0: stp = '0;
			1: stp = $urandom;
			default: stp = STEP_W'($urandom_range(1 << 20, 1 << 28));
		endcase
		program_regs(dly, dep, stp);
	endtask

	task automatic test_random_traffic();
		int blk;
		int n;
		logic [SAMPLE_W-1:0] smp;
		for (blk = 0; blk < 8; blk++) begin
			case (blk % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			random_regs();
			for (n = 0; n < 50; n++) begin
				case ($urandom_range(9))
					0: smp = S_MAX;
					1: smp = S_MIN;
					default: smp = SAMPLE_W'($urandom);
				endcase
				send_sample(smp, CH_W'($urandom_range(1)));
			end
			wait_all_results();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		program_regs(20'd1280, 20'sd512, 32'h0100_0000);
		hold_left <= HOLD_CYCLES;
		repeat (30)
			send_sample(SAMPLE_W'($urandom), CH_W'($urandom_range(1)));
		wait_all_results();
	endtask

	always @(posedge clk)
		if (hold_left > 0)
			hold_left <= hold_left - 1;

	always @(posedge clk) begin
		tap_result_t want;
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			if (awaited_outputs.size() == 0) begin
				$error("unexpected transaction: sample_out %0d, out_channel %0d",
					dout_bus.sample_out, dout_bus.out_channel);
				fail_count++;
			end else begin
				want = awaited_outputs.pop_front();
				if (dout_bus.sample_out !== want.sample) begin
					$error("sample_out: expected %0d, got %0d", want.sample,
						dout_bus.sample_out);
					fail_count++;
				end
				if (dout_bus.out_channel !== want.ch) begin
					$error("out_channel: expected %0d, got %0d", want.ch,
						dout_bus.out_channel);
					fail_count++;
				end
			end
		end
		dout_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		din_bus.valid = 1'b0;
		din_bus.sample_in = '0;
		din_bus.channel = '0;
		dout_bus.ready = 1'b0;
		clear_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass();
		test_fixed_delay();
		test_lfo_sweep();
		test_random_traffic();
		test_backpressure();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> modulated_fractional_delay_core.f
design/mfd_pkg.sv
design/mfd_in_if.sv
design/mfd_out_if.sv
design/mfd_ram.sv
design/mfd_front.sv
design/mfd_queue.sv
design/mfd_back.sv
design/modulated_fractional_delay_core.sv
sim/modulated_fractional_delay_core_tb.sv
